// File: hw/rtl/isk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isk_pkg: shared types and constants for the info string key lookup
// Holds the character constants, the queue depths and the structs that
// travel between the front, the parser and the result queue.
// ----------------------------------------------------------------------------
package isk_pkg;

    // Operation codes of an input transaction.
    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_INFO = 1'b1;

    // Character constants.
    localparam logic [7:0] SEP_CHAR    = 8'h5C;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Queue depths (powers of two).
    localparam int IQ_DEPTH = 4;
    localparam int OQ_DEPTH = 4;

    // One classified input transaction.
    typedef struct packed {
        logic       op;
        logic       last;
        logic [7:0] ch;
        logic [7:0] fch;
        logic       is_sep;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] value_char;
        logic       found;
        logic       end_of_value;
    } res_t;

    // Up to two results produced by the parser in one cycle.
    typedef struct packed {
        logic push0;
        logic push1;
        res_t res0;
        res_t res1;
    } back_out_t;

    // Fold a-z onto A-Z.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/info_string_key_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_string_key_lookup: search a backslash-separated info string for a key
// Top level joining the input queue, the parser and the result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full): each transaction carries op, char_in, last_in.
//   op=0 loads one search key character, last_in closing the key. op=1 feeds
//   one info string character, last_in marking the final one.
//   Result channel (empty/pop): value bytes of the first matching pair, each
//   with found=1 and end_of_value=0, then one end marker (value_char=0,
//   end_of_value=1) whose found bit tells whether the key matched.
//   Throughput: one character per cycle; the parser takes one transaction
//   each cycle as long as the result queue has room for two results.
//   An accepted character is written into the input queue; the parser reads
//   the input queue head and writes its results into the result queue, whose
//   oldest entry drives the result ports.
//   Reset empties both queues, clears the key length and returns the parser
//   to the start of a string; the key memory itself is not cleared.
//   When the receiver stops popping, the result queue fills, the parser
//   stalls, and full rises once the four-entry input queue is full.
// ----------------------------------------------------------------------------
module info_string_key_lookup #(
    parameter int MAX_KEY_CHARS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       op,
    input  logic [7:0] char_in,
    input  logic       last_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] value_char,
    output logic       found,
    output logic       end_of_value
);
    import isk_pkg::*;

    logic       head_valid;
    item_t      head;
    logic       head_pop;
    logic       out_space;
    back_out_t  bout;

    // Front: accept and classify characters.
    isk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .char_in    (char_in),
        .last_in    (last_in),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    // Back: key store and parser.
    isk_back #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (head_valid),
        .item       (head),
        .out_space  (out_space),
        .item_pop   (head_pop),
        .bout       (bout)
    );

    // Result queue.
    isk_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .bout         (bout),
        .space        (out_space),
        .empty        (empty),
        .pop          (pop),
        .value_char   (value_char),
        .found        (found),
        .end_of_value (end_of_value)
    );

endmodule

// File: hw/rtl/isk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isk_front: input queue and character classification
// Accepts input transactions, tags separators, folds the case of each
// character and holds them in a short queue for the parser.
// ----------------------------------------------------------------------------
module isk_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic          op,
    input  logic [7:0]    char_in,
    input  logic          last_in,
    output logic          head_valid,
    output isk_pkg::item_t head,
    input  logic          head_pop
);
    import isk_pkg::*;

    localparam int PW = $clog2(IQ_DEPTH);
    localparam int CW = $clog2(IQ_DEPTH + 1);

    item_t          entry_reg [IQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;
    item_t          new_item;

    // Classify the incoming character.
    always_comb
    begin
        new_item.op     = op;
        new_item.last   = last_in;
        new_item.ch     = char_in;
        new_item.fch    = fold_case(char_in);
        new_item.is_sep = (char_in == SEP_CHAR);
    end

    assign full       = (count_reg == CW'(IQ_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: hw/rtl/isk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isk_back: key store and info string parser
// Loads the search key into a memory and walks the info string one character
// per cycle when out_space is set, comparing each pair key against the stored key.
// ----------------------------------------------------------------------------
module isk_back #(
    parameter int MAX_KEY_CHARS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  isk_pkg::item_t      item,
    input  logic                out_space,
    output logic                item_pop,
    output isk_pkg::back_out_t  bout
);
    import isk_pkg::*;

    localparam int CW = $clog2(MAX_KEY_CHARS + 1);
    localparam int AW = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_KEY_CHARS);

    typedef enum logic [1:0] {
        PH_START,
        PH_KEY,
        PH_VALUE,
        PH_DONE
    } phase_t;

    // Folded key store, read one position ahead of the compare.
    logic [7:0]     key_mem [MAX_KEY_CHARS];
    logic [7:0]     key_rd_reg;
    logic           mem_we;
    logic [AW-1:0]  mem_wa;
    logic [AW-1:0]  mem_ra;

    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  key_len_reg, key_len_next;
    logic           key_ovf_reg, key_ovf_next;
    logic           key_open_reg, key_open_next;
    logic [CW-1:0]  cpos_reg, cpos_next;
    logic           mism_reg, mism_next;
    logic [CW-1:0]  len_base;
    logic           ovf_base;
    logic           in_range;
    logic           hit;
    logic           fire;

    assign fire     = item_valid && out_space;
    assign item_pop = fire;
    assign in_range = (cpos_reg < key_len_reg);
    assign hit      = !mism_reg && !key_ovf_reg && (cpos_reg == key_len_reg);
    assign mem_ra   = cpos_next[AW-1:0];

    // Parser next state and result generation.
    always_comb
    begin
        phase_next    = phase_reg;
        key_len_next  = key_len_reg;
        key_ovf_next  = key_ovf_reg;
        key_open_next = key_open_reg;
        cpos_next     = cpos_reg;
        mism_next     = mism_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        len_base      = key_open_reg ? key_len_reg : '0;
        ovf_base      = key_open_reg ? key_ovf_reg : 1'b0;
        bout          = '0;

        if (fire)
        begin
            if (item.op == OP_KEY)
            begin
                // Key load: a closed key restarts at length zero.
                if (len_base < MAX_C)
                begin
                    mem_we       = 1'b1;
                    mem_wa       = len_base[AW-1:0];
                    key_len_next = CW'(len_base + 1'b1);
                    key_ovf_next = ovf_base;
                end
                else
                begin
                    key_len_next = len_base;
                    key_ovf_next = 1'b1;
                end
                key_open_next = !item.last;
                phase_next    = PH_START;
                cpos_next     = '0;
                mism_next     = 1'b0;
            end
            else
            begin
                key_open_next = 1'b0;
                unique case (phase_reg)
                    PH_START:
                    begin
                        phase_next = PH_KEY;
                        cpos_next  = '0;
                        mism_next  = 1'b0;
                        if (!item.is_sep)
                        begin
                            if (in_range)
                            begin
                                mism_next = (item.fch != key_rd_reg);
                                cpos_next = CW'(cpos_reg + 1'b1);
                            end
                            else
                            begin
                                mism_next = 1'b1;
                            end
                        end
                        if (item.last)
                        begin
                            bout.push0 = 1'b1;
                            bout.res0  = '{8'h00, 1'b0, 1'b1};
                        end
                    end
                    PH_KEY:
                    begin
                        if (item.is_sep)
                        begin
                            mism_next  = !hit;
                            phase_next = PH_VALUE;
                            if (item.last)
                            begin
                                bout.push0 = 1'b1;
                                bout.res0  = '{8'h00, hit, 1'b1};
                            end
                        end
                        else
                        begin
                            if (in_range)
                            begin
                                mism_next = mism_reg || (item.fch != key_rd_reg);
                                cpos_next = CW'(cpos_reg + 1'b1);
                            end
                            else
                            begin
                                mism_next = 1'b1;
                            end
                            if (item.last)
                            begin
                                bout.push0 = 1'b1;
                                bout.res0  = '{8'h00, 1'b0, 1'b1};
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        if (item.is_sep)
                        begin
                            if (!mism_reg)
                            begin
                                bout.push0 = 1'b1;
                                bout.res0  = '{8'h00, 1'b1, 1'b1};
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_KEY;
                                cpos_next  = '0;
                                mism_next  = 1'b0;
                                if (item.last)
                                begin
                                    bout.push0 = 1'b1;
                                    bout.res0  = '{8'h00, 1'b0, 1'b1};
                                end
                            end
                        end
                        else if (!mism_reg)
                        begin
                            bout.push0 = 1'b1;
                            bout.res0  = '{item.ch, 1'b1, 1'b0};
                            if (item.last)
                            begin
                                bout.push1 = 1'b1;
                                bout.res1  = '{8'h00, 1'b1, 1'b1};
                            end
                        end
                        else if (item.last)
                        begin
                            bout.push0 = 1'b1;
                            bout.res0  = '{8'h00, 1'b0, 1'b1};
                        end
                    end
                    PH_DONE:
                    begin
                        // Match already reported: remaining characters are ignored.
                    end
                    default:
                    begin
                    end
                endcase

                // The last character returns the parser to the start of string.
                if (item.last)
                begin
                    phase_next = PH_START;
                    cpos_next  = '0;
                    mism_next  = 1'b0;
                end
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            key_len_reg  <= '0;
            key_ovf_reg  <= 1'b0;
            key_open_reg <= 1'b0;
            cpos_reg     <= '0;
            mism_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            key_len_reg  <= key_len_next;
            key_ovf_reg  <= key_ovf_next;
            key_open_reg <= key_open_next;
            cpos_reg     <= cpos_next;
            mism_reg     <= mism_next;
        end
    end

    // Key memory: one write port, one registered read port with write forwarding.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_wa] <= item.fch;
        end
        if (mem_we && (mem_wa == mem_ra))
        begin
            key_rd_reg <= item.fch;
        end
        else
        begin
            key_rd_reg <= key_mem[mem_ra];
        end
    end

endmodule

// File: hw/rtl/isk_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isk_outq: result queue
// Takes up to two results per cycle from the parser and presents the
// oldest one on the result ports until it is popped.
// ----------------------------------------------------------------------------
module isk_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  isk_pkg::back_out_t  bout,
    output logic                space,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          value_char,
    output logic                found,
    output logic                end_of_value
);
    import isk_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    res_t           entry_reg [OQ_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [1:0]     push_cnt;
    logic           do_pop;
    logic [PW-1:0]  wr_ptr_inc;

    // Room for two results is needed before the parser may take a character.
    assign space      = (count_reg <= CW'(OQ_DEPTH - 2));
    assign empty      = (count_reg == '0);
    assign do_pop     = pop && !empty;
    assign push_cnt   = {1'b0, bout.push0} + {1'b0, bout.push1};
    assign wr_ptr_inc = PW'(wr_ptr_reg + 1'b1);

    assign value_char   = entry_reg[rd_ptr_reg].value_char;
    assign found        = entry_reg[rd_ptr_reg].found;
    assign end_of_value = entry_reg[rd_ptr_reg].end_of_value;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = PW'(wr_ptr_reg + push_cnt);
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = CW'(count_reg + push_cnt - {1'b0, do_pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (bout.push0)
        begin
            entry_reg[wr_ptr_reg] <= bout.res0;
        end
        if (bout.push1)
        begin
            entry_reg[wr_ptr_inc] <= bout.res1;
        end
    end

endmodule

// File: tb/sv/info_string_key_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// info_string_key_lookup_tb: self-checking bench for the info string lookup
// Loads search keys and streams backslash-separated info strings through the
// push/full side, predicts every value byte and end marker in a local model
// of the parser, and checks each transaction popped from the result side.
// Sender and receiver stall at random in two of three phases; the last runs at full rate.
// ----------------------------------------------------------------------------
module info_string_key_lookup_tb;

    import isk_pkg::*;

    localparam int KEY_SLOTS  = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_SHOWN  = 10;

    typedef enum logic [1:0] {PH_START, PH_KEY, PH_VALUE, PH_DONE} parse_phase_t;

    typedef struct {
        logic       op;
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic       op = OP_KEY;
    logic [7:0] char_in = 8'h00;
    logic       last_in = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] value_char;
    logic       found;
    logic       end_of_value;

    info_string_key_lookup #(
        .MAX_KEY_CHARS(KEY_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .op(op),
        .char_in(char_in),
        .last_in(last_in),
        .empty(empty),
        .pop(pop),
        .value_char(value_char),
        .found(found),
        .end_of_value(end_of_value)
    );

    // Stimulus and scoreboard storage.
    char_item_t pending_chars[$];
    res_t       expected_results[$];
    logic [7:0] loaded_key[$];
    int         queued_chars = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    char_item_t drive_item;
    res_t       want_res;

    // Lookup model state.
    logic [7:0]   key_store [KEY_SLOTS];
    logic [6:0]   key_len = '0;
    logic         key_ovf = 1'b0;
    logic         key_open = 1'b0;
    parse_phase_t phase = PH_START;
    logic [6:0]   cmp_pos = '0;
    logic         pair_miss = 1'b0;

    // Clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] upper_fold(input logic [7:0] c);
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic void expect_result(input logic [7:0] v, input logic f, input logic e);
        res_t r;
        r.value_char   = v;
        r.found        = f;
        r.end_of_value = e;
        expected_results.push_back(r);
    endfunction

    function automatic void open_pair();
        phase     = PH_KEY;
        cmp_pos   = '0;
        pair_miss = 1'b0;
    endfunction

    function automatic void restart_string();
        phase     = PH_START;
        cmp_pos   = '0;
        pair_miss = 1'b0;
    endfunction

    // Compare one pair key character against the stored key.
    function automatic void compare_key_char(input logic [7:0] c);
        if (cmp_pos < key_len && cmp_pos < KEY_SLOTS)
        begin
            if (upper_fold(c) != upper_fold(key_store[cmp_pos[5:0]]))
            begin
                pair_miss = 1'b1;
            end
            cmp_pos = cmp_pos + 7'd1;
        end
        else
        begin
            pair_miss = 1'b1;
        end
    endfunction

    // Advance the lookup model by one accepted transaction.
    function automatic void lookup_predict(input logic o, input logic [7:0] c, input logic l);
        logic hit;
        if (o == OP_KEY)
        begin
            if (!key_open)
            begin
                key_len  = '0;
                key_ovf  = 1'b0;
                key_open = 1'b1;
            end
            if (key_len < KEY_SLOTS)
            begin
                key_store[key_len[5:0]] = c;
                key_len = key_len + 7'd1;
            end
            else
            begin
                key_ovf = 1'b1;
            end
            if (l)
            begin
                key_open = 1'b0;
            end
            restart_string();
            return;
        end
        key_open = 1'b0;
        case (phase)
            PH_START:
            begin
                open_pair();
                if (c != SEP_CHAR)
                begin
                    compare_key_char(c);
                end
                if (l)
                begin
                    expect_result(8'h00, 1'b0, 1'b1);
                end
            end
            PH_KEY:
            begin
                if (c == SEP_CHAR)
                begin
                    hit = !pair_miss && !key_ovf && (cmp_pos == key_len);
                    pair_miss = !hit;
                    phase = PH_VALUE;
                    if (l)
                    begin
                        expect_result(8'h00, hit, 1'b1);
                    end
                end
                else
                begin
                    compare_key_char(c);
                    if (l)
                    begin
                        expect_result(8'h00, 1'b0, 1'b1);
                    end
                end
            end
            PH_VALUE:
            begin
                if (c == SEP_CHAR)
                begin
                    if (!pair_miss)
                    begin
                        expect_result(8'h00, 1'b1, 1'b1);
                        phase = PH_DONE;
                    end
                    else
                    begin
                        open_pair();
                        if (l)
                        begin
                            expect_result(8'h00, 1'b0, 1'b1);
                        end
                    end
                end
                else if (!pair_miss)
                begin
                    expect_result(c, 1'b1, 1'b0);
                    if (l)
                    begin
                        expect_result(8'h00, 1'b1, 1'b1);
                    end
                end
                else if (l)
                begin
                    expect_result(8'h00, 1'b0, 1'b1);
                end
            end
            default:
            begin
            end
        endcase
        if (l)
        begin
            restart_string();
        end
    endfunction

    function automatic void queue_char(input logic o, input logic [7:0] c, input logic l);
        char_item_t it;
        it.op   = o;
        it.ch   = c;
        it.last = l;
        pending_chars.push_back(it);
        queued_chars++;
    endfunction

    // Mostly letters of either case, some digits, some arbitrary bytes; never a separator.
    function automatic logic [7:0] rand_key_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 70)
        begin
            c = LOWER_A + 8'($urandom_range(25));
            if ($urandom_range(1) == 1)
            begin
                c = c - CASE_OFFSET;
            end
        end
        else if (r < 85)
        begin
            c = 8'h30 + 8'($urandom_range(9));
        end
        else
        begin
            c = 8'($urandom_range(255));
        end
        if (c == SEP_CHAR)
        begin
            c = 8'h00;
        end
        return c;
    endfunction

    // Queue one lookup: usually a key load and a well-formed string, sometimes noise.
    function automatic void add_lookup();
        logic [7:0] info[$];
        logic [7:0] pair_key[$];
        logic [7:0] c;
        int         r;
        int         n;
        int         pairs;
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(8, 1);
            repeat (n)
            begin
                queue_char(1'($urandom_range(1)), 8'($urandom_range(255)),
                           $urandom_range(3) == 0);
            end
            return;
        end

        // New search key; mostly short, a few near or past the store size.
        if (loaded_key.size() == 0 || $urandom_range(99) < 75)
        begin
            r = $urandom_range(99);
            if (r < 88)
            begin
                n = $urandom_range(6, 1);
            end
            else if (r < 96)
            begin
                n = $urandom_range(KEY_SLOTS, KEY_SLOTS - 8);
            end
            else
            begin
                n = $urandom_range(KEY_SLOTS + 6, KEY_SLOTS + 1);
            end
            loaded_key.delete();
            for (int i = 0; i < n; i++)
            begin
                c = rand_key_char();
                loaded_key.push_back(c);
                queue_char(OP_KEY, c, i == n - 1);
            end
        end

        // Info string built from pairs whose keys hit, nearly hit or miss.
        if ($urandom_range(99) < 70)
        begin
            info.push_back(SEP_CHAR);
        end
        pairs = $urandom_range(4, 1);
        for (int p = 0; p < pairs; p++)
        begin
            pair_key.delete();
            r = $urandom_range(99);
            if (r < 60)
            begin
                foreach (loaded_key[i])
                begin
                    c = loaded_key[i];
                    if (upper_fold(c | CASE_OFFSET) != (c | CASE_OFFSET)
                        && $urandom_range(1) == 1)
                    begin
                        c = c ^ CASE_OFFSET;
                    end
                    pair_key.push_back(c);
                end
                if (r >= 45)
                begin
                    case ($urandom_range(2))
                        0: if (pair_key.size() != 0) void'(pair_key.pop_back());
                        1: pair_key.push_back(rand_key_char());
                        default: if (pair_key.size() != 0)
                            pair_key[$urandom_range(pair_key.size() - 1)] = rand_key_char();
                    endcase
                end
            end
            else
            begin
                n = $urandom_range(4);
                repeat (n)
                begin
                    pair_key.push_back(rand_key_char());
                end
            end
            foreach (pair_key[i])
            begin
                info.push_back(pair_key[i]);
            end
            info.push_back(SEP_CHAR);
            n = $urandom_range(5);
            repeat (n)
            begin
                c = 8'($urandom_range(255));
                info.push_back(c == SEP_CHAR ? 8'hFF : c);
            end
            if (p != pairs - 1)
            begin
                info.push_back(SEP_CHAR);
            end
        end

        // Odd endings: a trailing separator, a dangling key, or a cut string.
        r = $urandom_range(99);
        if (r < 10)
        begin
            info.push_back(SEP_CHAR);
        end
        else if (r < 20)
        begin
            info.push_back(SEP_CHAR);
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                info.push_back(rand_key_char());
            end
        end
        else if (r < 25)
        begin
            n = $urandom_range(info.size(), 1);
            while (info.size() > n)
            begin
                void'(info.pop_back());
            end
        end
        foreach (info[i])
        begin
            queue_char(OP_INFO, info[i], i == info.size() - 1);
        end
    endfunction

    // Wait until every queued character is accepted and every result has arrived.
    task automatic drain();
        while (pending_chars.size() != 0 || push || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Driver: offers the next pending character and records each accepted transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                lookup_predict(op, char_in, last_in);
            end
            if (!push || !full)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    drive_item = pending_chars.pop_front();
                    push    <= 1'b1;
                    op      <= drive_item.op;
                    char_in <= drive_item.ch;
                    last_in <= drive_item.last;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each popped result against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                    begin
                        $display("unexpected result: value=%02h found=%0b end=%0b",
                                 value_char, found, end_of_value);
                    end
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (value_char !== want_res.value_char || found !== want_res.found
                        || end_of_value !== want_res.end_of_value)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN)
                        begin
                            $display("mismatch: expected value=%02h found=%0b end=%0b,",
                                     want_res.value_char, want_res.found,
                                     want_res.end_of_value,
                                     " got value=%02h found=%0b end=%0b",
                                     value_char, found, end_of_value);
                        end
                    end
                end
            end
            pop <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: ends the run when neither side has moved a transaction for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("info_string_key_lookup_tb NOT OK");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty key before any load matches an empty pair key; value holds 00 and FF.
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, 8'h00, 1'b0);
        queue_char(OP_INFO, 8'hFF, 1'b1);
        // Case-insensitive match, closing separator, then ignored tail.
        queue_char(OP_KEY, LOWER_A, 1'b0);
        queue_char(OP_KEY, 8'h5A, 1'b1);
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, 8'h41, 1'b0);
        queue_char(OP_INFO, LOWER_Z, 1'b0);
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, 8'h31, 1'b0);
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, 8'h71, 1'b1);
        // Key left open is closed by the string; string ends after a value separator.
        queue_char(OP_KEY, 8'h6B, 1'b0);
        queue_char(OP_INFO, 8'h78, 1'b0);
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, 8'h79, 1'b0);
        queue_char(OP_INFO, SEP_CHAR, 1'b1);
        // A new key abandons the lookup in progress; then a string ending inside a key.
        queue_char(OP_INFO, SEP_CHAR, 1'b0);
        queue_char(OP_INFO, 8'h6B, 1'b0);
        queue_char(OP_KEY, 8'h62, 1'b1);
        queue_char(OP_INFO, 8'h62, 1'b1);

        // Sender idles lightly, receiver heavily.
        tx_idle_pct = 38;
        rx_idle_pct = 86;
        while (queued_chars < 550)
        begin
            add_lookup();
        end
        drain();

        // Sender idles heavily, receiver lightly.
        tx_idle_pct = 86;
        rx_idle_pct = 38;
        while (queued_chars < 1100)
        begin
            add_lookup();
        end
        drain();

        // Full rate on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (queued_chars < 1650)
        begin
            add_lookup();
        end
        drain();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("info_string_key_lookup_tb OK");
        end
        else
        begin
            $display("info_string_key_lookup_tb NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/isk_pkg.sv
hw/rtl/isk_front.sv
hw/rtl/isk_back.sv
hw/rtl/isk_outq.sv
hw/rtl/info_string_key_lookup.sv
tb/sv/info_string_key_lookup_tb.sv
